>>> src/header_torus_route_classifier_core_defines.svh
// Assertion shorthands for the route classifier.
`ifndef HEADER_TORUS_ROUTE_CLASSIFIER_CORE_DEFINES_SVH
`define HEADER_TORUS_ROUTE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication.
`define HTRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HTRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/htrc_pkg.sv
package htrc_pkg;

  localparam int ID_W    = 14;
  localparam int K_W     = 5;
  localparam int DIG_W   = 4;
  localparam int DIST_W  = 7;
  localparam int DOUT_W  = 6;
  localparam int CLS_W   = 2;
  localparam int NEVAL   = 5;

  localparam logic [K_W-1:0]    K_RESET  = 5'd4;
  localparam logic [DOUT_W-1:0] DOUT_MAX = 6'd63;

  typedef enum logic [CLS_W-1:0] {
    CLS_SHORTER,
    CLS_SAME,
    CLS_LONGER
  } htrc_cls_t;

  // Distance evaluations, in the order they run.
  typedef enum logic [2:0] {
    EV_BASE,
    EV_UP_HDR,
    EV_DN_HDR,
    EV_UP_DIG,
    EV_DN_DIG
  } htrc_eval_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [1:0] bsel;
  } htrc_dig_ctl_t;

  typedef struct packed {
    logic start;
    logic step;
  } htrc_dist_ctl_t;

  function automatic htrc_cls_t classify(input logic [DIST_W-1:0] nb,
                                         input logic [DIST_W-1:0] base);
    htrc_cls_t c;
    if (nb < base) begin
      c = CLS_SHORTER;
    end else if (nb == base) begin
      c = CLS_SAME;
    end else begin
      c = CLS_LONGER;
    end
    return c;
  endfunction

endpackage

>>> src/htrc_if.sv
interface htrc_query_if;
  logic                      valid;
  logic                      ready;
  logic [htrc_pkg::ID_W-1:0] current_node;
  logic [htrc_pkg::ID_W-1:0] dest_node;

  modport source (output valid, output current_node, output dest_node, input ready);
  modport sink (input valid, input current_node, input dest_node, output ready);
endinterface

interface htrc_route_if;
  logic                        valid;
  logic                        ready;
  logic                        valid_res;
  logic [htrc_pkg::DOUT_W-1:0] current_distance;
  logic [htrc_pkg::ID_W-1:0]   hop_up_header_node;
  logic [htrc_pkg::ID_W-1:0]   hop_down_header_node;
  logic [htrc_pkg::ID_W-1:0]   hop_up_digit_node;
  logic [htrc_pkg::ID_W-1:0]   hop_down_digit_node;
  logic [htrc_pkg::CLS_W-1:0]  class_up_header;
  logic [htrc_pkg::CLS_W-1:0]  class_down_header;
  logic [htrc_pkg::CLS_W-1:0]  class_up_digit;
  logic [htrc_pkg::CLS_W-1:0]  class_down_digit;

  modport source (
    output valid, output valid_res, output current_distance,
    output hop_up_header_node, output hop_down_header_node,
    output hop_up_digit_node, output hop_down_digit_node,
    output class_up_header, output class_down_header,
    output class_up_digit, output class_down_digit,
    input ready
  );
  modport sink (
    input valid, input valid_res, input current_distance,
    input hop_up_header_node, input hop_down_header_node,
    input hop_up_digit_node, input hop_down_digit_node,
    input class_up_header, input class_down_header,
    input class_up_digit, input class_down_digit,
    output ready
  );
endinterface

interface htrc_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [htrc_pkg::K_W-1:0] data_arity;

  modport source (output valid, output data_arity, input ready);
  modport sink (input valid, input data_arity, output ready);
endinterface

>>> src/header_torus_route_classifier_core.sv
// Route classifier for a header torus: a node id is a header digit (radix
// DATA_DIMS) over DATA_DIMS data digits (radix data_arity, clamped to
// 2..MAX_ARITY). One query (current node, destination node) yields one
// result: a valid flag, the strategic distance to the destination
// (saturated at 63), the four neighbor ids, and for each neighbor whether
// it is shorter, the same or longer than the current node. Ids at or above
// DATA_DIMS * k^DATA_DIMS give valid_res = 0 and all other fields zero.
// The block handles one query at a time. The restoring digit extractor works
// through the header and every data digit of both ids, and the distance
// evaluator visits one ring position per cycle in each of five evaluations.
// The result sits in an output register; query.ready returns once it is
// loaded, so the next query can be taken while the result still waits.
// Writes to data_arity are always taken and apply to the next accepted
// query.
`include "header_torus_route_classifier_core_defines.svh"

module header_torus_route_classifier_core #(
  parameter int DATA_DIMS = 3,
  parameter int MAX_ARITY = 16
) (
  input  logic         clk,
  input  logic         rst,
  htrc_cfg_if.sink     cfg,
  htrc_query_if.sink   query,
  htrc_route_if.source route
);

  localparam int HDR_W  = $clog2(DATA_DIMS);
  localparam int WIDX_W = $clog2(DATA_DIMS + 1);
  localparam int PW     = htrc_pkg::ID_W + htrc_pkg::K_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WGT,
    S_DEC,
    S_ESET,
    S_ESWP,
    S_ESTO,
    S_MUL,
    S_FIN
  } state_t;

  state_t state;

  logic [htrc_pkg::K_W-1:0]    data_arity;
  logic [htrc_pkg::K_W-1:0]    k_r;
  logic [htrc_pkg::K_W-1:0]    k_eff;
  logic [htrc_pkg::ID_W-1:0]   cur_id;
  logic [htrc_pkg::ID_W-1:0]   dst_id;

  // place weights k^j, kept modulo 2^14 with a flag once they pass 2^14
  logic [htrc_pkg::ID_W-1:0]   w [DATA_DIMS+1];
  logic                        wsat [DATA_DIMS+1];
  logic [htrc_pkg::ID_W-1:0]   wrun;
  logic                        wrun_sat;
  logic [WIDX_W-1:0]           wj;
  logic [PW-1:0]               wprod;

  // decode sequencing
  logic                        phase;
  logic [WIDX_W-1:0]           j;
  logic [1:0]                  bsel;
  logic [WIDX_W-1:0]           widx;
  logic [htrc_pkg::ID_W-1:0]   w_sel;
  logic                        wsat_sel;
  logic                        j_is_x;

  // decoded nodes; data digits live in rotating lines, digit 1 at tap 0
  logic [HDR_W-1:0]            ch;
  logic [HDR_W-1:0]            dh;
  logic                        ok;
  logic [htrc_pkg::DIG_W-1:0]  cdv [DATA_DIMS];
  logic [htrc_pkg::DIG_W-1:0]  ddv [DATA_DIMS];
  logic [htrc_pkg::DIG_W-1:0]  xdig;
  logic [htrc_pkg::DIG_W-1:0]  ddx;
  logic [htrc_pkg::ID_W-1:0]   wx;
  logic [htrc_pkg::ID_W-1:0]   wn;
  logic [htrc_pkg::ID_W-1:0]   prod;
  logic [htrc_pkg::ID_W-1:0]   nm1wn;
  logic [PW-1:0]               mprod;
  logic [PW-1:0]               nprod;

  // distance evaluations
  htrc_pkg::htrc_eval_t        e;
  logic [HDR_W-1:0]            u;
  logic [htrc_pkg::DIST_W-1:0] dists [htrc_pkg::NEVAL];
  logic [htrc_pkg::DIST_W-1:0] total;

  logic [htrc_pkg::DIG_W-1:0]  km1_dig;
  logic [htrc_pkg::DIG_W-1:0]  x_up;
  logic [htrc_pkg::DIG_W-1:0]  x_dn;
  logic [HDR_W-1:0]            h_up;
  logic [HDR_W-1:0]            h_dn;
  logic                        dig_ev;
  logic [htrc_pkg::DIG_W-1:0]  new_dig;
  logic [HDR_W-1:0]            s_sel;
  logic [DATA_DIMS-1:0]        set_sel;
  logic [htrc_pkg::DIG_W-1:0]  a_sel;

  logic [htrc_pkg::ID_W-1:0]   hop_uh;
  logic [htrc_pkg::ID_W-1:0]   hop_dh;
  logic [htrc_pkg::ID_W-1:0]   hop_ud;
  logic [htrc_pkg::ID_W-1:0]   hop_dd;

  htrc_pkg::htrc_dig_ctl_t     dig_ctl;
  htrc_pkg::htrc_dist_ctl_t    dist_ctl;
  logic [htrc_pkg::ID_W-1:0]   dig_id;
  logic [htrc_pkg::DIG_W-1:0]  q_out;
  logic [htrc_pkg::ID_W-1:0]   rem_out;

  assign cfg.ready   = 1'b1;
  assign query.ready = (state == S_IDLE);

  always_comb begin
    if (data_arity < htrc_pkg::K_W'(2)) begin
      k_eff = htrc_pkg::K_W'(2);
    end else if (data_arity > htrc_pkg::K_W'(MAX_ARITY)) begin
      k_eff = htrc_pkg::K_W'(MAX_ARITY);
    end else begin
      k_eff = data_arity;
    end
  end

  always_comb begin
    wprod    = PW'(wrun) * PW'(k_r);
    widx     = WIDX_W'(DATA_DIMS) - j;
    w_sel    = w[widx];
    wsat_sel = wsat[widx];
    j_is_x   = (j == WIDX_W'(ch) + WIDX_W'(1));
    mprod    = PW'(wx) * PW'(k_r - htrc_pkg::K_W'(1));
    nprod    = PW'(wn) * PW'(DATA_DIMS - 1);
  end

  // neighbor coordinates of the current node
  always_comb begin
    km1_dig = htrc_pkg::DIG_W'(k_r - htrc_pkg::K_W'(1));
    x_up    = (xdig == km1_dig) ? '0 : xdig + htrc_pkg::DIG_W'(1);
    x_dn    = (xdig == '0) ? km1_dig : xdig - htrc_pkg::DIG_W'(1);
    h_up    = (ch == HDR_W'(DATA_DIMS - 1)) ? '0 : ch + HDR_W'(1);
    h_dn    = (ch == '0) ? HDR_W'(DATA_DIMS - 1) : ch - HDR_W'(1);
  end

  // operands of the running evaluation
  always_comb begin
    dig_ev  = (e == htrc_pkg::EV_UP_DIG) || (e == htrc_pkg::EV_DN_DIG);
    new_dig = (e == htrc_pkg::EV_UP_DIG) ? x_up : x_dn;
    case (e)
      htrc_pkg::EV_UP_HDR: s_sel = h_up;
      htrc_pkg::EV_DN_HDR: s_sel = h_dn;
      default:             s_sel = ch;
    endcase
    for (int i = 0; i < DATA_DIMS; i++) begin
      set_sel[i] = (cdv[i] != ddv[i]);
      if (dig_ev && (HDR_W'(i) == ch)) begin
        set_sel[i] = (new_dig != ddx);
      end
      if ((HDR_W'(i) == s_sel) || (HDR_W'(i) == dh)) begin
        set_sel[i] = 1'b1;
      end
    end
    a_sel = (dig_ev && (u == ch)) ? new_dig : cdv[0];
  end

  // neighbor ids as offsets of the current id, modulo 2^14
  always_comb begin
    hop_uh = (ch == HDR_W'(DATA_DIMS - 1)) ? cur_id - nm1wn : cur_id + wn;
    hop_dh = (ch == '0) ? cur_id + nm1wn : cur_id - wn;
    hop_ud = (xdig == km1_dig) ? cur_id - prod : cur_id + wx;
    hop_dd = (xdig == '0) ? cur_id + prod : cur_id - wx;
  end

  always_comb begin
    dig_ctl.load  = ((state == S_WGT) && (wj == WIDX_W'(DATA_DIMS))) ||
                    ((state == S_DEC) && (bsel == 2'd0) && !phase &&
                     (j == WIDX_W'(DATA_DIMS)));
    dig_ctl.step  = (state == S_DEC);
    dig_ctl.bsel  = bsel;
    dig_id        = (state == S_WGT) ? cur_id : dst_id;
    dist_ctl.start = (state == S_ESET);
    dist_ctl.step  = (state == S_ESWP);
  end

  htrc_digit_unit u_digit (
    .clk     (clk),
    .ctl     (dig_ctl),
    .id_in   (dig_id),
    .w       (w_sel),
    .w_sat   (wsat_sel),
    .q_out   (q_out),
    .rem_out (rem_out)
  );

  htrc_dist_unit #(
    .DATA_DIMS (DATA_DIMS)
  ) u_dist (
    .clk    (clk),
    .ctl    (dist_ctl),
    .set_in (set_sel),
    .s_in   (s_sel),
    .d_in   (dh),
    .u      (u),
    .a_dig  (a_sel),
    .b_dig  (ddv[0]),
    .k      (k_r),
    .total  (total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      route.valid <= 1'b0;
      data_arity  <= htrc_pkg::K_RESET;
    end else begin
      if (cfg.valid) begin
        data_arity <= cfg.data_arity;
      end
      if (route.valid && route.ready) begin
        route.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // take the query and start the weight table at k^0
          if (query.valid) begin
            cur_id   <= query.current_node;
            dst_id   <= query.dest_node;
            k_r      <= k_eff;
            w[0]     <= htrc_pkg::ID_W'(1);
            wsat[0]  <= 1'b0;
            wrun     <= htrc_pkg::ID_W'(1);
            wrun_sat <= 1'b0;
            wj       <= WIDX_W'(1);
            state    <= S_WGT;
          end
        end
        S_WGT: begin
          // one multiply per weight; flag weights that pass the id range
          w[wj]    <= wprod[htrc_pkg::ID_W-1:0];
          wsat[wj] <= wrun_sat | (|wprod[PW-1:htrc_pkg::ID_W]);
          wrun     <= wprod[htrc_pkg::ID_W-1:0];
          wrun_sat <= wrun_sat | (|wprod[PW-1:htrc_pkg::ID_W]);
          wj       <= wj + WIDX_W'(1);
          if (wj == WIDX_W'(DATA_DIMS)) begin
            phase <= 1'b0;
            j     <= '0;
            bsel  <= 2'(htrc_pkg::DIG_W - 1);
            ok    <= 1'b1;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          bsel <= bsel - 2'd1;
          if (bsel == 2'd0) begin
            if (j == '0) begin
              // header digit; the id is valid only if the quotient is below
              // DATA_DIMS and nothing is left over at the top weight
              if (!phase) begin
                ch <= q_out[HDR_W-1:0];
                wn <= w_sel;
              end else begin
                dh <= q_out[HDR_W-1:0];
              end
              ok <= ok & (q_out < htrc_pkg::DIG_W'(DATA_DIMS)) &
                    (wsat_sel | (rem_out < w_sel));
            end else if (!phase) begin
              for (int i = 0; i < DATA_DIMS - 1; i++) begin
                cdv[i] <= cdv[i+1];
              end
              cdv[DATA_DIMS-1] <= q_out;
              if (j_is_x) begin
                xdig <= q_out;
                wx   <= w_sel;
              end
            end else begin
              for (int i = 0; i < DATA_DIMS - 1; i++) begin
                ddv[i] <= ddv[i+1];
              end
              ddv[DATA_DIMS-1] <= q_out;
              if (j_is_x) begin
                ddx <= q_out;
              end
            end
            if (j == WIDX_W'(DATA_DIMS)) begin
              j <= '0;
              if (!phase) begin
                phase <= 1'b1;
              end else begin
                e     <= htrc_pkg::EV_BASE;
                state <= S_ESET;
              end
            end else begin
              j <= j + WIDX_W'(1);
            end
          end
        end
        S_ESET: begin
          u     <= '0;
          state <= S_ESWP;
        end
        S_ESWP: begin
          // rotate so the next data digit reaches tap 0
          for (int i = 0; i < DATA_DIMS - 1; i++) begin
            cdv[i] <= cdv[i+1];
            ddv[i] <= ddv[i+1];
          end
          cdv[DATA_DIMS-1] <= cdv[0];
          ddv[DATA_DIMS-1] <= ddv[0];
          u <= u + HDR_W'(1);
          if (u == HDR_W'(DATA_DIMS - 1)) begin
            state <= S_ESTO;
          end
        end
        S_ESTO: begin
          dists[e] <= total;
          if (e == htrc_pkg::EV_DN_DIG) begin
            state <= S_MUL;
          end else begin
            e     <= htrc_pkg::htrc_eval_t'(3'(e) + 3'd1);
            state <= S_ESET;
          end
        end
        S_MUL: begin
          prod  <= mprod[htrc_pkg::ID_W-1:0];
          nm1wn <= nprod[htrc_pkg::ID_W-1:0];
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free, then load the result
          if (!route.valid || route.ready) begin
            route.valid <= 1'b1;
            route.valid_res <= ok;
            if (ok) begin
              route.current_distance <=
                (dists[htrc_pkg::EV_BASE] > htrc_pkg::DIST_W'(htrc_pkg::DOUT_MAX)) ?
                htrc_pkg::DOUT_MAX : dists[htrc_pkg::EV_BASE][htrc_pkg::DOUT_W-1:0];
              route.hop_up_header_node   <= hop_uh;
              route.hop_down_header_node <= hop_dh;
              route.hop_up_digit_node    <= hop_ud;
              route.hop_down_digit_node  <= hop_dd;
              route.class_up_header   <= htrc_pkg::classify(
                dists[htrc_pkg::EV_UP_HDR], dists[htrc_pkg::EV_BASE]);
              route.class_down_header <= htrc_pkg::classify(
                dists[htrc_pkg::EV_DN_HDR], dists[htrc_pkg::EV_BASE]);
              route.class_up_digit    <= htrc_pkg::classify(
                dists[htrc_pkg::EV_UP_DIG], dists[htrc_pkg::EV_BASE]);
              route.class_down_digit  <= htrc_pkg::classify(
                dists[htrc_pkg::EV_DN_DIG], dists[htrc_pkg::EV_BASE]);
            end else begin
              route.current_distance     <= '0;
              route.hop_up_header_node   <= '0;
              route.hop_down_header_node <= '0;
              route.hop_up_digit_node    <= '0;
              route.hop_down_digit_node  <= '0;
              route.class_up_header      <= '0;
              route.class_down_header    <= '0;
              route.class_up_digit       <= '0;
              route.class_down_digit     <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `HTRC_ASSERT_NEXT(a_busy_after_accept, clk, rst, query.valid && query.ready, !query.ready, "query accepted while a previous one is in progress")
  `HTRC_ASSERT_NOW(a_invalid_zero, clk, rst, route.valid && !route.valid_res, (route.current_distance == '0) && (route.hop_up_header_node == '0) && (route.hop_down_digit_node == '0), "invalid result carries nonzero fields")
  `HTRC_ASSERT_NOW(a_sweep_range, clk, rst, state == S_ESWP, u < HDR_W'(DATA_DIMS - 1) || u == HDR_W'(DATA_DIMS - 1), "sweep position past the last ring point")

endmodule

>>> src/htrc_digit_unit.sv
// Restoring digit extractor: one quotient bit per step against a place weight.
module htrc_digit_unit (
  input  logic                          clk,
  input  htrc_pkg::htrc_dig_ctl_t       ctl,
  input  logic [htrc_pkg::ID_W-1:0]     id_in,
  input  logic [htrc_pkg::ID_W-1:0]     w,
  input  logic                          w_sat,
  output logic [htrc_pkg::DIG_W-1:0]    q_out,
  output logic [htrc_pkg::ID_W-1:0]     rem_out
);

  localparam int TW = htrc_pkg::ID_W + htrc_pkg::DIG_W - 1;

  logic [htrc_pkg::ID_W-1:0]  rem;
  logic [htrc_pkg::DIG_W-1:0] q;
  logic [htrc_pkg::DIG_W-1:0] q_base;
  logic [TW-1:0]              trial;
  logic                       take;

  always_comb begin
    trial   = TW'(w) << ctl.bsel;
    // a saturated weight exceeds every id, so the bit is never taken
    take    = !w_sat && (TW'(rem) >= trial);
    rem_out = take ? rem - trial[htrc_pkg::ID_W-1:0] : rem;
    q_base  = (ctl.bsel == 2'(htrc_pkg::DIG_W - 1)) ? '0 : q;
    q_out   = q_base | (take ? (htrc_pkg::DIG_W'(1) << ctl.bsel) : '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= id_in;
    end else if (ctl.step) begin
      rem <= rem_out;
    end
    if (ctl.step) begin
      q <= q_out;
    end
  end

endmodule

>>> src/htrc_dist_unit.sv
// Strategic distance evaluator: one ring position per step. Each step adds
// the ring cost of one data digit and tries the sweep with the gap that ends
// at that position, keeping the cheapest sweep.
module htrc_dist_unit #(
  parameter int DATA_DIMS = 3
) (
  input  logic                          clk,
  input  htrc_pkg::htrc_dist_ctl_t      ctl,
  input  logic [DATA_DIMS-1:0]          set_in,
  input  logic [$clog2(DATA_DIMS)-1:0]  s_in,
  input  logic [$clog2(DATA_DIMS)-1:0]  d_in,
  input  logic [$clog2(DATA_DIMS)-1:0]  u,
  input  logic [htrc_pkg::DIG_W-1:0]    a_dig,
  input  logic [htrc_pkg::DIG_W-1:0]    b_dig,
  input  logic [htrc_pkg::K_W-1:0]      k,
  output logic [htrc_pkg::DIST_W-1:0]   total
);

  localparam int HDR_W = $clog2(DATA_DIMS);
  localparam int XW    = HDR_W + 1;
  localparam int SW    = HDR_W + 2;

  logic [DATA_DIMS-1:0]        pset;
  logic [HDR_W-1:0]            s_r;
  logic [htrc_pkg::DIST_W-1:0] acc;
  logic [SW-1:0]               best;

  logic [HDR_W-1:0]            v;
  logic [XW-1:0]               p_w;
  logic [HDR_W-1:0]            len;
  logic [HDR_W-1:0]            sp;
  logic [HDR_W-1:0]            dp;
  logic [SW-1:0]               c1;
  logic [SW-1:0]               c2;
  logic [SW-1:0]               c;
  logic [htrc_pkg::DIG_W-1:0]  diff;
  logic [htrc_pkg::K_W-1:0]    alt;
  logic [htrc_pkg::K_W-1:0]    rc;

  // (a - b) mod DATA_DIMS for a, b below DATA_DIMS
  function automatic logic [HDR_W-1:0] ring_off(input logic [HDR_W-1:0] a,
                                                input logic [HDR_W-1:0] b);
    logic [XW-1:0] r;
    if (a >= b) begin
      r = XW'(a) - XW'(b);
    end else begin
      r = XW'(a) + XW'(DATA_DIMS) - XW'(b);
    end
    return r[HDR_W-1:0];
  endfunction

  always_comb begin
    // nearest set point below u, wrapping; u itself when it stands alone
    v = u;
    for (int off = DATA_DIMS; off >= 1; off--) begin
      if (XW'(u) >= XW'(off)) begin
        p_w = XW'(u) - XW'(off);
      end else begin
        p_w = XW'(u) + XW'(DATA_DIMS) - XW'(off);
      end
      if (pset[p_w[HDR_W-1:0]]) begin
        v = p_w[HDR_W-1:0];
      end
    end
    len = ring_off(v, u);
    sp  = ring_off(s_r, u);
    dp  = ring_off(d_in, u);
    c1  = SW'(sp) + SW'(len) + (SW'(len) - SW'(dp));
    c2  = (SW'(len) - SW'(sp)) + SW'(len) + SW'(dp);
    c   = (c1 < c2) ? c1 : c2;

    diff = (a_dig > b_dig) ? a_dig - b_dig : b_dig - a_dig;
    alt  = k - htrc_pkg::K_W'(diff);
    rc   = (htrc_pkg::K_W'(diff) < alt) ? htrc_pkg::K_W'(diff) : alt;

    total = acc + htrc_pkg::DIST_W'(best);
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      pset <= set_in;
      s_r  <= s_in;
      acc  <= '0;
      best <= '1;
    end else if (ctl.step) begin
      acc <= acc + htrc_pkg::DIST_W'(rc);
      if (pset[u] && (c < best)) begin
        best <= c;
      end
    end
  end

endmodule
